// ===== rtl/blmfd_pkg.sv =====
// Shared types and constants for the balancing-sequence modular term engine.
package blmfd_pkg;

  localparam int unsigned BLMFD_WORD_BITS = 64;

  // Modular products issued per index bit, in issue order
  typedef enum logic [2:0] {
    OP_SIXA,
    OP_AT,
    OP_BB,
    OP_AA,
    OP_SIXD
  } mul_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_GO,
    ST_WAIT,
    ST_FIN,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    shift;
    logic    mul_start;
    logic    mul_wr;
    logic    fin;
    logic    out_load;
    mul_op_e op;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mod_zero_in;
    logic cur_bit;
    logic cnt_zero;
    logic mul_done;
  } sts_t;

endpackage

// ===== rtl/balancing_lucas_mod_fast_doubling_top.sv =====
// Top level of the balancing-sequence term engine (U_n mod m by fast doubling).
// One request at a time. After acceptance the block shifts past the leading zero bits
// of the index (up to WORD_BITS-1 of them), then spends per remaining index bit
// four products (five when the bit is set) on one shared bit-serial modular multiplier
// (each product a start, WORD_BITS steps and a done), then closes the bit. A zero modulus
// goes straight to the result with invalid_o set and a zero term. The result sits in
// an output register, so a new request is accepted while the previous result is
// still stalled.
module balancing_lucas_mod_fast_doubling_top #(
  parameter int unsigned WORD_BITS = blmfd_pkg::BLMFD_WORD_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [WORD_BITS-1:0] index_i,
  input  logic [WORD_BITS-1:0] modulus_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [WORD_BITS-1:0] term_value_o,
  output logic                 invalid_o
);
  import blmfd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  blmfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  blmfd_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .index_i      (index_i),
    .modulus_i    (modulus_i),
    .term_value_o (term_value_o),
    .invalid_o    (invalid_o)
  );

endmodule

// ===== rtl/blmfd_mulmod.sv =====
// Bit-serial modular multiplier: one bit of y per cycle, doubling then conditional add.
module blmfd_mulmod #(
  parameter int unsigned WORD_BITS = blmfd_pkg::BLMFD_WORD_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_BITS-1:0] x_i,
  input  logic [WORD_BITS-1:0] y_i,
  input  logic [WORD_BITS-1:0] m_i,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] prod_o
);
  import blmfd_pkg::*;

  localparam int unsigned CW = $clog2(WORD_BITS);

  logic                 busy_q;
  logic                 done_q;
  logic [CW-1:0]        cnt_q;
  logic [WORD_BITS-1:0] acc_q;
  logic [WORD_BITS-1:0] y_q;
  logic [WORD_BITS-1:0] dbl;
  logic [WORD_BITS-1:0] acc_d;

  // (x + y) mod m for x, y below m
  function automatic logic [WORD_BITS-1:0] madd(input logic [WORD_BITS-1:0] x,
                                                input logic [WORD_BITS-1:0] y,
                                                input logic [WORD_BITS-1:0] m);
    logic [WORD_BITS-1:0] room;
    room = m - y;
    return (x >= room) ? (x - room) : (x + y);
  endfunction

  // one step of the shift-and-add product
  always_comb begin
    dbl   = madd(acc_q, acc_q, m_i);
    acc_d = y_q[WORD_BITS-1] ? madd(dbl, x_i, m_i) : dbl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(WORD_BITS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand and accumulator registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      y_q   <= y_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      y_q   <= {y_q[WORD_BITS-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== rtl/blmfd_datapath.sv =====
// Datapath: term pair, scratch terms, index shifter, multiplier and output register.
module blmfd_datapath #(
  parameter int unsigned WORD_BITS = blmfd_pkg::BLMFD_WORD_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  blmfd_pkg::cmd_t       cmd_i,
  output blmfd_pkg::sts_t       sts_o,
  input  logic [WORD_BITS-1:0]  index_i,
  input  logic [WORD_BITS-1:0]  modulus_i,
  output logic [WORD_BITS-1:0]  term_value_o,
  output logic                  invalid_o
);
  import blmfd_pkg::*;

  localparam int unsigned CW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] a_q, b_q, c_q, d_q, t_q, six_q, m_q, n_q;
  logic [CW-1:0]        cnt_q;
  logic                 mzero_q;
  logic [WORD_BITS-1:0] term_q;
  logic                 inv_q;
  logic [WORD_BITS-1:0] mx, my, prod;
  logic                 mul_done;
  logic [WORD_BITS-1:0] six_init;

  function automatic logic [WORD_BITS-1:0] madd(input logic [WORD_BITS-1:0] x,
                                                input logic [WORD_BITS-1:0] y,
                                                input logic [WORD_BITS-1:0] m);
    logic [WORD_BITS-1:0] room;
    room = m - y;
    return (x >= room) ? (x - room) : (x + y);
  endfunction

  function automatic logic [WORD_BITS-1:0] msub(input logic [WORD_BITS-1:0] x,
                                                input logic [WORD_BITS-1:0] y,
                                                input logic [WORD_BITS-1:0] m);
    return (x >= y) ? (x - y) : (m - (y - x));
  endfunction

  // 6 mod m for the small moduli
  always_comb begin
    case (modulus_i)
      WORD_BITS'(1), WORD_BITS'(2), WORD_BITS'(3), WORD_BITS'(6): six_init = '0;
      WORD_BITS'(4): six_init = WORD_BITS'(2);
      WORD_BITS'(5): six_init = WORD_BITS'(1);
      default:       six_init = WORD_BITS'(6);
    endcase
  end

  // multiplier operand select
  always_comb begin
    unique case (cmd_i.op)
      OP_SIXA: begin mx = six_q; my = a_q; end
      OP_AT:   begin mx = a_q;   my = t_q; end
      OP_BB:   begin mx = b_q;   my = b_q; end
      OP_AA:   begin mx = a_q;   my = a_q; end
      OP_SIXD: begin mx = six_q; my = d_q; end
      default: begin mx = a_q;   my = a_q; end
    endcase
  end

  blmfd_mulmod #(.WORD_BITS(WORD_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .x_i     (mx),
    .y_i     (my),
    .m_i     (m_q),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q     <= index_i;
      m_q     <= modulus_i;
      mzero_q <= (modulus_i == '0);
      a_q     <= '0;
      b_q     <= (modulus_i == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
      six_q   <= six_init;
      cnt_q   <= CW'(WORD_BITS - 1);
    end
    if (cmd_i.shift) begin
      n_q   <= {n_q[WORD_BITS-2:0], 1'b0};
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.mul_wr) begin
      unique case (cmd_i.op)
        OP_SIXA: t_q <= msub(madd(b_q, b_q, m_q), prod, m_q);
        OP_AT:   c_q <= prod;
        OP_BB:   d_q <= prod;
        OP_AA:   d_q <= msub(d_q, prod, m_q);
        OP_SIXD: t_q <= msub(prod, c_q, m_q);
        default: t_q <= t_q;
      endcase
    end
    // close one index bit: double, then step if the bit is set
    if (cmd_i.fin) begin
      if (n_q[WORD_BITS-1]) begin
        a_q <= d_q;
        b_q <= t_q;
      end else begin
        a_q <= c_q;
        b_q <= d_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q <= '0;
      inv_q  <= 1'b0;
    end else if (cmd_i.out_load) begin
      term_q <= mzero_q ? '0 : a_q;
      inv_q  <= mzero_q;
    end
  end

  assign sts_o.mod_zero_in = (modulus_i == '0);
  assign sts_o.cur_bit     = n_q[WORD_BITS-1];
  assign sts_o.cnt_zero    = (cnt_q == '0);
  assign sts_o.mul_done    = mul_done;

  assign term_value_o = term_q;
  assign invalid_o    = inv_q;

endmodule

// ===== rtl/blmfd_ctrl.sv =====
// Controller: sequences the index scan, the four or five products per bit and result hand-off.
module blmfd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  blmfd_pkg::sts_t sts_i,
  output blmfd_pkg::cmd_t cmd_o
);
  import blmfd_pkg::*;

  state_e  state_q, state_d;
  mul_op_e op_q, op_d;
  logic    out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_SIXA;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.op = op_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.mod_zero_in ? ST_DONE : ST_SCAN;
        end
      end
      // skip leading zero bits of the index
      ST_SCAN: begin
        if (!sts_i.cnt_zero && !sts_i.cur_bit) begin
          cmd_o.shift = 1'b1;
        end else begin
          op_d    = OP_SIXA;
          state_d = ST_GO;
        end
      end
      ST_GO: begin
        cmd_o.mul_start = 1'b1;
        state_d         = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.mul_wr = 1'b1;
          state_d      = ST_GO;
          unique case (op_q)
            OP_SIXA: op_d = OP_AT;
            OP_AT:   op_d = OP_BB;
            OP_BB:   op_d = OP_AA;
            OP_AA: begin
              if (sts_i.cur_bit) op_d = OP_SIXD;
              else state_d = ST_FIN;
            end
            OP_SIXD: state_d = ST_FIN;
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        if (sts_i.cnt_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.shift = 1'b1;
          op_d        = OP_SIXA;
          state_d     = ST_GO;
        end
      end
      ST_DONE: begin
        if (!(out_valid_q && out_stall_i)) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/blmfd_checker.sv =====
// Port-level checks for the term engine, bound to the top level.
module blmfd_checker #(
  parameter int unsigned WORD_BITS = blmfd_pkg::BLMFD_WORD_BITS
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [WORD_BITS-1:0] term_value_o,
  input logic                 invalid_o
);

  // an invalid result always carries a zero term
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |-> term_value_o == '0)
    else $error("invalid result with nonzero term");

  // only one request in flight
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

  // a new result appears only out of a busy cycle
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request in flight");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(term_value_o)
                                   && $stable(invalid_o))
    else $error("stalled result changed");

endmodule

bind balancing_lucas_mod_fast_doubling_top blmfd_checker #(.WORD_BITS(WORD_BITS)) u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .term_value_o (term_value_o),
  .invalid_o    (invalid_o)
);

// ===== test/balancing_lucas_mod_fast_doubling_checker.sv =====
// Checker for the balancing-sequence term engine: predicts U_n mod m and compares results.
`timescale 1ns / 100ps

module balancing_lucas_mod_fast_doubling_checker #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [WORD_BITS-1:0] index_i,
  input  logic [WORD_BITS-1:0] modulus_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [WORD_BITS-1:0] term_value_i,
  input  logic                 invalid_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct {
    logic [WORD_BITS-1:0] term;
    logic                 inv;
  } term_rec_t;

  term_rec_t term_q[$];

  // Modular add with 65-bit headroom; both operands below m
  function automatic logic [63:0] mod_add(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[63:0];
  endfunction

  function automatic logic [63:0] mod_sub(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    return (x >= y) ? x - y : m - (y - x);
  endfunction

  // Exact product then reduce, 128-bit
  function automatic logic [63:0] mod_mul(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    p = p % {64'd0, m};
    return p[63:0];
  endfunction

  function automatic logic [63:0] balancing_term(logic [63:0] n, logic [63:0] m);
    logic [63:0] a, b, six, t, c, d;
    int top;
    a = 0;
    b = 64'd1 % m;
    six = 64'd6 % m;
    if (n == 0) return 0;
    top = WORD_BITS - 1;
    while (top > 0 && !n[top]) top--;
    for (int i = top; i >= 0; i--) begin
      t = mod_sub(mod_add(b, b, m), mod_mul(six, a, m), m);
      c = mod_mul(a, t, m);
      d = mod_sub(mod_mul(b, b, m), mod_mul(a, a, m), m);
      if (!n[i]) begin
        a = c;
        b = d;
      end else begin
        a = d;
        b = mod_sub(mod_mul(six, d, m), c, m);
      end
    end
    return a;
  endfunction

  assign pending_o = term_q.size();

  // Predict on accepted requests, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    term_rec_t exp_r, got_r;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (modulus_i == 0) begin
          exp_r.term = 0;
          exp_r.inv  = 1'b1;
        end else begin
          exp_r.term = balancing_term(64'(index_i), 64'(modulus_i));
          exp_r.inv  = 1'b0;
        end
        term_q.insert(term_q.size(), exp_r);
      end
      if (out_valid_i && !out_stall_i) begin
        if (term_q.size() == 0) begin
          $error("unexpected result term_value=%0d invalid=%0d", term_value_i, invalid_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          got_r = term_q.pop_front();
          if (got_r.term !== term_value_i || got_r.inv !== invalid_i) begin
            if (got_r.term !== term_value_i)
              $error("term_value expected %0d actual %0d", got_r.term, term_value_i);
            if (got_r.inv !== invalid_i)
              $error("invalid expected %0d actual %0d", got_r.inv, invalid_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== test/balancing_lucas_mod_fast_doubling_top_test.sv =====
// Testbench top for the balancing-sequence term engine: stimulus, pacing and verdict.
`timescale 1ns / 100ps

module balancing_lucas_mod_fast_doubling_top_test;
  import blmfd_pkg::*;

  localparam int unsigned WB = BLMFD_WORD_BITS;
  localparam int N_RAND = 80;
  localparam longint CYCLE_LIMIT = 64'd15_000_000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  logic [WB-1:0] index_i = '0;
  logic [WB-1:0] modulus_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  logic [WB-1:0] term_value_o;
  logic          invalid_o;
  int            fail_count;
  int            pending;
  bit            hold_long = 1'b0;
  longint        cycle_cnt = 0;

  always #5 clk_i = ~clk_i;

  balancing_lucas_mod_fast_doubling_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .index_i, .modulus_i,
    .out_valid_o, .out_stall_i, .term_value_o, .invalid_o
  );

  balancing_lucas_mod_fast_doubling_checker #(.WORD_BITS(WB)) chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .index_i, .modulus_i,
    .out_valid_i(out_valid_o), .out_stall_i, .term_value_i(term_value_o),
    .invalid_i(invalid_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Offer one request, waiting for acceptance; valid stays up for a back-to-back follower
  task automatic send_request(logic [WB-1:0] n, logic [WB-1:0] m);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    index_i    <= n;
    modulus_i  <= m;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Receiver pacing; a long hold-off on request
  initial begin
    int wait_n;
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (3000) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_long = 1'b0;
      end else if (out_valid_o && !out_stall_i) begin
        wait_n = $urandom_range(0, 9);
        if (wait_n != 0) begin
          out_stall_i <= 1'b1;
          repeat (wait_n) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [63:0] n, m;
    int sel;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero modulus, zero index, modulus one, small terms, extremes
    send_request(64'd5, 64'd0);
    send_request(64'd0, 64'd0);
    send_request(64'd0, 64'd97);
    send_request(64'd123, 64'd1);
    send_request(64'd1, 64'd1000);
    send_request(64'd2, 64'd1000);
    send_request(64'd3, 64'd1000);
    send_request(64'd10, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'd2);
    send_request(64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFC5);
    send_request(64'd1, 64'd6);
    send_request(64'd7, 64'd5);
    send_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);

    // Fill up behind a long output hold-off
    hold_long = 1'b1;
    for (int k = 0; k < 4; k++) send_request(64'(k + 4), 64'd1009);

    // Random: mostly short indices, a few full-width
    for (int k = 0; k < N_RAND; k++) begin
      sel = $urandom_range(0, 19);
      n = rand64();
      m = rand64();
      if (sel < 12) n = n & 64'hFF;
      else if (sel < 16) n = n & 64'hFFFF;
      if (sel == 3) m = 0;
      else if (sel == 4) m = m & 64'hF;
      send_request(n, m);
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
